/* src/sv39w_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39w_pkg
// Shared types and constants for the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39w_pkg;

   // request opcodes
   localparam logic [1:0] OP_WRITE      = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_WALK_LOAD  = 2'd2;
   localparam logic [1:0] OP_WALK_STORE = 2'd3;

   // response status codes
   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_MISS_L2 = 3'd1;
   localparam logic [2:0] STS_MISS_L1 = 3'd2;
   localparam logic [2:0] STS_MISS_L0 = 3'd3;
   localparam logic [2:0] STS_OUT_WIN = 3'd4;

   // configuration register indexes
   localparam logic CSR_ROOT_PAGE = 1'b0;
   localparam logic CSR_BASE_PPN  = 1'b1;

   // walk levels
   localparam logic [1:0] LVL_2 = 2'd2;
   localparam logic [1:0] LVL_1 = 2'd1;
   localparam logic [1:0] LVL_0 = 2'd0;

   // PTE bit positions (Sv39)
   localparam int PTE_V_BIT   = 0;
   localparam int PTE_A_BIT   = 6;
   localparam int PTE_D_BIT   = 7;
   localparam int PTE_PPN_LSB = 10;
   localparam int PPN_W       = 44;
   localparam int SLOT_W      = 9;

   localparam logic [63:0] PTE_A_MASK = 64'd1 << PTE_A_BIT;
   localparam logic [63:0] PTE_D_MASK = 64'd1 << PTE_D_BIT;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [38:0] vaddr;
      logic [11:0] entry_index;
      logic [63:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] data;
   } rsp_type;

endpackage

/* src/sv39w_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39w_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module sv39w_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/sv39_walk_access_dirty_update_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_walk_access_dirty_update_core
// Three-level Sv39 walker over an on-chip PTE store, with A/D update.
// ----------------------------------------------------------------------------
// The PTE store is one single-port RAM of TABLE_PAGES*512 words with a
// registered read, so every entry access goes through that one port. A write
// item finishes as it is taken, a read item when its word returns, and a full
// walk makes three dependent entry reads, the leaf write-back sharing the
// cycle in which the leaf word returns. A walk that misses or leaves the
// table window ends at the level where it does so. After reset the block
// zeroes the store, one word a cycle, through all TABLE_PAGES*512 words
// before it takes the first request word; configuration writes are taken at
// any time. One request is in flight at a time; a finished response waits in
// the output register while the next request is taken.
// ----------------------------------------------------------------------------
module sv39_walk_access_dirty_update_core #(
   parameter int TABLE_PAGES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sv39w_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sv39w_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [43:0]        csr_wdata
);
   import sv39w_pkg::*;

   localparam int DEPTH  = TABLE_PAGES * 512;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PG_W   = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_WALK  = 5'b01000,
      S_HOLD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [1:0]  level_ff, level_in;
   logic [1:0]  op_ff, op_in;
   logic [38:0] va_ff, va_in;
   logic [2:0]  root_page_ff;
   logic [43:0] base_ppn_ff;
   logic [2:0]  hold_status_ff, hold_status_in;
   logic [63:0] hold_data_ff, hold_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_payload_ff, rsp_payload_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [63:0]       mem_wdata;
   logic [63:0]       mem_rdata;

   logic        accept;
   logic        out_free;
   logic        fin;
   logic [2:0]  fin_status;
   logic [63:0] fin_data;
   logic        idx_ok;
   logic        root_ok;
   logic [44:0] ppn_diff;
   logic        in_win;
   logic [PG_W-1:0] next_page;
   logic [SLOT_W-1:0] next_vpn;
   logic [63:0] leaf_word;

   sv39w_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_ok    = (32'(req_payload.entry_index) < DEPTH);
   assign root_ok   = (32'(root_page_ff) < TABLE_PAGES);

   // next-level table page from the pointer PPN, relative to the window
   assign ppn_diff  = {1'b0, mem_rdata[PTE_PPN_LSB +: PPN_W]} - {1'b0, base_ppn_ff};
   assign in_win    = !ppn_diff[44] && (ppn_diff[43:0] < 44'(TABLE_PAGES));
   assign next_page = PG_W'(ppn_diff[43:0]);
   assign next_vpn  = (level_ff == LVL_2) ? va_ff[29:21] : va_ff[20:12];
   assign leaf_word = mem_rdata | PTE_A_MASK |
                      ((op_ff == OP_WALK_STORE) ? PTE_D_MASK : 64'd0);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      addr_in        = addr_ff;
      level_in       = level_ff;
      op_in          = op_ff;
      va_in          = va_ff;
      hold_status_in = hold_status_ff;
      hold_data_in   = hold_data_ff;
      mem_we         = 1'b0;
      mem_addr       = addr_ff;
      mem_wdata      = 64'd0;
      fin            = 1'b0;
      fin_status     = STS_OK;
      fin_data       = 64'd0;

      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req_payload.opcode;
               va_in = req_payload.vaddr;
               case (req_payload.opcode)
                  OP_WRITE: begin
                     mem_we    = idx_ok;
                     mem_addr  = ADDR_W'(req_payload.entry_index);
                     mem_wdata = req_payload.entry_value;
                     fin       = 1'b1;
                  end
                  OP_READ: begin
                     mem_addr = ADDR_W'(req_payload.entry_index);
                     if (idx_ok) begin
                        state_in = S_READ;
                     end else begin
                        fin        = 1'b1;
                        fin_status = STS_OUT_WIN;
                     end
                  end
                  default: begin
                     mem_addr = ADDR_W'({PG_W'(root_page_ff), req_payload.vaddr[38:30]});
                     addr_in  = mem_addr;
                     level_in = LVL_2;
                     if (root_ok) begin
                        state_in = S_WALK;
                     end else begin
                        fin        = 1'b1;
                        fin_status = STS_OUT_WIN;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            fin      = 1'b1;
            fin_data = mem_rdata;
         end
         S_WALK: begin
            if (!mem_rdata[PTE_V_BIT]) begin
               fin = 1'b1;
               case (level_ff)
                  LVL_2:   fin_status = STS_MISS_L2;
                  LVL_1:   fin_status = STS_MISS_L1;
                  default: fin_status = STS_MISS_L0;
               endcase
            end else if (level_ff == LVL_0) begin
               // leaf: write back with A (and D for a store)
               mem_we    = 1'b1;
               mem_addr  = addr_ff;
               mem_wdata = leaf_word;
               fin       = 1'b1;
               fin_data  = leaf_word;
            end else if (!in_win) begin
               fin        = 1'b1;
               fin_status = STS_OUT_WIN;
            end else begin
               mem_addr = ADDR_W'({next_page, next_vpn});
               addr_in  = mem_addr;
               level_in = level_ff - 1'b1;
            end
         end
         S_HOLD: begin
            fin        = 1'b1;
            fin_status = hold_status_ff;
            fin_data   = hold_data_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            state_in = S_IDLE;
         end else begin
            hold_status_in = fin_status;
            hold_data_in   = fin_data;
            state_in       = S_HOLD;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (fin && out_free) begin
         rsp_valid_in          = 1'b1;
         rsp_payload_in.status = fin_status;
         rsp_payload_in.data   = fin_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         root_page_ff <= 3'd0;
         base_ppn_ff  <= 44'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROOT_PAGE: root_page_ff <= csr_wdata[2:0];
               CSR_BASE_PPN:  base_ppn_ff  <= csr_wdata;
               default:       root_page_ff <= root_page_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      level_ff       <= level_in;
      op_ff          <= op_in;
      va_ff          <= va_in;
      hold_status_ff <= hold_status_in;
      hold_data_ff   <= hold_data_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
